// File: design/vpp_pkg.sv
// Shared types, constants and the pattern table for the vibration pattern PWM.
// No dependencies; used by vpp_stage and vibration_pattern_pwm.
package vpp_pkg;

    localparam int TICK_W       = 16;   // tick counter width
    localparam int TBL_W        = 12;   // width of period and duty entries in the table
    localparam int REP_W        = 9;    // segment repeat counter width
    localparam int SEG_W        = 2;    // segment index width
    localparam int PAT_W        = 4;    // pattern select width
    localparam int CFG_W        = 16;   // power-on buzz length register width
    localparam int COUNT_WIDTH_DEF = 12;

    localparam logic [CFG_W-1:0] POWER_ON_RESET = 16'd1000;
    localparam logic [PAT_W-1:0] PAT_MIN        = 4'd1;
    localparam logic [PAT_W-1:0] PAT_MAX        = 4'd10;

    // one segment of a pattern
    typedef struct packed {
        logic [TBL_W-1:0] per;
        logic [TBL_W-1:0] duty;
        logic [REP_W-1:0] reps;
    } t_seg_entry;

    // sequencer position
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [REP_W-1:0] rep;
    } t_seq;

    function automatic logic [SEG_W-1:0] pat_nseg(input logic [PAT_W-1:0] pat);
        logic [SEG_W-1:0] n;
        case (pat)
            4'd5:    n = 2'd2;
            4'd6:    n = 2'd3;
            4'd7:    n = 2'd3;
            4'd10:   n = 2'd2;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic t_seg_entry pat_seg(input logic [PAT_W-1:0] pat,
                                           input logic [SEG_W-1:0] seg);
        t_seg_entry e;
        e = '0;
        case (pat)
            4'd2: e = '{12'd19,   12'd15,   9'd0};
            4'd3: e = '{12'd19,   12'd19,   9'd0};
            4'd4: e = '{12'd768,  12'd614,  9'd0};
            4'd5: begin
                case (seg)
                    2'd0:    e = '{12'd420, 12'd230, 9'd16};
                    2'd1:    e = '{12'd19,  12'd10,  9'd300};
                    default: e = '0;
                endcase
            end
            4'd6: begin
                case (seg)
                    2'd0:    e = '{12'd2077, 12'd1039, 9'd5};
                    2'd1:    e = '{12'd1653, 12'd615,  9'd5};
                    default: e = '{12'd360,  12'd189,  9'd20};
                endcase
            end
            4'd7: begin
                case (seg)
                    2'd0:    e = '{12'd1357, 12'd1132, 9'd10};
                    2'd1:    e = '{12'd258,  12'd128,  9'd5};
                    default: e = '{12'd713,  12'd250,  9'd10};
                endcase
            end
            4'd8: e = '{12'd1823, 12'd1216, 9'd0};
            4'd9: e = '{12'd700,  12'd323,  9'd0};
            4'd10: begin
                case (seg)
                    2'd0:    e = '{12'd2025, 12'd1012, 9'd5};
                    2'd1:    e = '{12'd1215, 12'd607,  9'd10};
                    default: e = '0;
                endcase
            end
            default: e = '{12'd19, 12'd9, 9'd0};
        endcase
        return e;
    endfunction

endpackage

// File: design/vibration_pattern_pwm.sv
// Top level of the tick-driven vibration motor PWM with built-in patterns.
// Depends on vpp_pkg and vpp_stage.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one transaction is one timer
//    tick carrying i_restart and i_pattern.
//  - Output channel (o_out_valid / i_out_stall): exactly one result
//    transaction per tick: motor level, period end flag, segment, buzz busy.
//  - Config: i_cfg_we writes i_cfg_data into the power-on buzz length
//    (reset 1000 ticks; 0 acts as 1). Write only while the block is idle.
// Timing:
//  - The tick is accepted, all state updates in that cycle and the result
//    sits in the output register the next cycle.
//  - Throughput 1 tick per cycle when not stalled, set by the single pass
//    through the two chained sequencer steps and the tick compare.
//  - A held output stalls input only while the result register is full and
//    i_out_stall is high; otherwise a new tick is taken while it drains.
// Reset (synchronous, active low): motor off, buzz armed, PWM idle until a
//  restart tick; the result register is emptied.
module vibration_pattern_pwm
    import vpp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_restart,
    input  logic [PAT_W-1:0] i_pattern,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_motor_on,
    output logic             o_period_end,
    output logic [SEG_W-1:0] o_segment,
    output logic             o_notice_busy,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // state
    logic [CFG_W-1:0]       r_power_on_ticks;
    logic [TICK_W-1:0]      r_tick, n_tick;
    logic [COUNT_WIDTH-1:0] r_period, n_period;
    logic [COUNT_WIDTH-1:0] r_duty, n_duty;
    logic [COUNT_WIDTH-1:0] r_next_period, n_next_period;
    logic [COUNT_WIDTH-1:0] r_next_duty, n_next_duty;
    t_seq                   r_seq, n_seq;
    logic                   r_notice, n_notice;
    logic                   r_work, n_work;
    logic                   r_drive, n_drive;
    logic                   n_pend;

    // result register
    logic                   r_out_valid;
    logic                   r_pend;

    logic                   in_fire;

    // two sequencer steps: one for restart, one for a period end
    t_seq                   seq_a_in, seq_a_out, seq_b_in, seq_b_out;
    logic                   load_a, load_b;
    logic [COUNT_WIDTH-1:0] per_a, duty_a, per_b, duty_b;
    logic [TICK_W-1:0]      tick_inc;
    logic [CFG_W-1:0]       limit;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign seq_a_in = '0;

    vpp_stage #(.COUNT_WIDTH(COUNT_WIDTH)) u_stage_restart (
        .i_pattern (i_pattern),
        .i_seq     (seq_a_in),
        .o_seq     (seq_a_out),
        .o_load    (load_a),
        .o_period  (per_a),
        .o_duty    (duty_a)
    );

    vpp_stage #(.COUNT_WIDTH(COUNT_WIDTH)) u_stage_period (
        .i_pattern (i_pattern),
        .i_seq     (seq_b_in),
        .o_seq     (seq_b_out),
        .o_load    (load_b),
        .o_period  (per_b),
        .o_duty    (duty_b)
    );

    always_comb begin
        n_tick        = r_tick;
        n_period      = r_period;
        n_duty        = r_duty;
        n_next_period = r_next_period;
        n_next_duty   = r_next_duty;
        n_seq         = r_seq;
        n_notice      = r_notice;
        n_work        = r_work;
        n_drive       = r_drive;
        n_pend        = 1'b0;
        limit         = (r_power_on_ticks == '0) ? CFG_W'(1) : r_power_on_ticks;

        // restart clears the counters and stages the first segment
        if (i_restart) begin
            n_tick   = '0;
            n_period = COUNT_WIDTH'(1);
            n_work   = 1'b1;
            n_seq    = seq_a_out;
            if (load_a) begin
                n_next_period = per_a;
                n_next_duty   = duty_a;
            end
        end

        tick_inc = n_tick + 1'b1;

        if (r_notice) begin
            // power-on buzz runs before any PWM counting
            n_tick  = tick_inc;
            n_drive = 1'b1;
            if (tick_inc >= limit) begin
                n_tick   = '0;
                n_notice = 1'b0;
                n_drive  = 1'b0;
            end
        end else if (n_work) begin
            n_tick = tick_inc;
            if (tick_inc == TICK_W'(n_period)) begin
                // period end wins over duty match, so full duty keeps the motor on
                n_tick   = '0;
                n_drive  = (n_duty != '0);
                n_period = n_next_period;
                n_duty   = n_next_duty;
                n_pend   = 1'b1;
            end else if (tick_inc == TICK_W'(n_duty)) begin
                n_drive = 1'b0;
            end
        end

        seq_b_in = n_seq;
        if (n_pend) begin
            n_seq = seq_b_out;
            if (load_b) begin
                n_next_period = per_b;
                n_next_duty   = duty_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_on_ticks <= POWER_ON_RESET;
            r_tick           <= '0;
            r_period         <= COUNT_WIDTH'(1);
            r_duty           <= '0;
            r_next_period    <= COUNT_WIDTH'(1);
            r_next_duty      <= '0;
            r_seq            <= '0;
            r_notice         <= 1'b1;
            r_work           <= 1'b0;
            r_drive          <= 1'b0;
            r_out_valid      <= 1'b0;
            r_pend           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_power_on_ticks <= i_cfg_data;
            end
            if (in_fire) begin
                r_tick        <= n_tick;
                r_period      <= n_period;
                r_duty        <= n_duty;
                r_next_period <= n_next_period;
                r_next_duty   <= n_next_duty;
                r_seq         <= n_seq;
                r_notice      <= n_notice;
                r_work        <= n_work;
                r_drive       <= n_drive;
                r_pend        <= n_pend;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motor_on    = r_drive;
    assign o_period_end  = r_pend;
    assign o_segment     = r_seq.seg;
    assign o_notice_busy = r_notice;

`ifndef SYNTHESIS
    // a period can only end once the buzz is over
    a_pend_no_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_period_end |-> !o_notice_busy)
        else $error("period end reported during power-on buzz");

    // the buzz never comes back without a reset
    a_notice_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_notice |=> !r_notice)
        else $error("power-on buzz restarted");

    // no pattern has a fourth segment
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.seg != 2'd3)
        else $error("segment index out of range");

    // motor is only driven by the buzz or by active PWM
    a_drive_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_notice && !r_work |-> !r_drive)
        else $error("motor driven while idle");
`endif

endmodule

// File: design/vpp_stage.sv
// Pattern sequencer step: picks the staged period and duty and advances the
// segment position. Purely combinational. Depends on vpp_pkg.
module vpp_stage
    import vpp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic [PAT_W-1:0]       i_pattern,
    input  t_seq                   i_seq,
    output t_seq                   o_seq,
    output logic                   o_load,
    output logic [COUNT_WIDTH-1:0] o_period,
    output logic [COUNT_WIDTH-1:0] o_duty
);

    logic [PAT_W-1:0] pat;
    logic [SEG_W-1:0] nseg;
    logic [SEG_W-1:0] sel;
    t_seg_entry       ent;
    logic [REP_W-1:0] rep_inc;
    logic [SEG_W:0]   seg_inc;

    always_comb begin
        pat = ((i_pattern < PAT_MIN) || (i_pattern > PAT_MAX)) ? PAT_MIN : i_pattern;
        nseg = pat_nseg(pat);
        sel = (nseg == 2'd1) ? '0 : i_seq.seg;
        ent = pat_seg(pat, sel);
        rep_inc = i_seq.rep + 1'b1;
        seg_inc = {1'b0, i_seq.seg} + 1'b1;

        o_period = COUNT_WIDTH'(ent.per);
        o_duty   = COUNT_WIDTH'(ent.duty);
        o_seq    = i_seq;
        o_load   = 1'b1;

        if (nseg == 2'd1) begin
            // single segment: sequencer position untouched
        end else if (i_seq.seg >= nseg) begin
            // stale segment after a pattern change: rewind, keep staged values
            o_seq  = '0;
            o_load = 1'b0;
        end else if (rep_inc >= ent.reps) begin
            o_seq.rep = '0;
            o_seq.seg = (seg_inc >= {1'b0, nseg}) ? '0 : seg_inc[SEG_W-1:0];
        end else begin
            o_seq.rep = rep_inc;
        end
    end

endmodule
